/* hdl/i2c_register_access_master_assert.svh */
// Assertion macros for the I2C register access master.
// Needs clk and rst in the scope where the macros are used.
`ifndef I2C_REGISTER_ACCESS_MASTER_ASSERT_SVH
`define I2C_REGISTER_ACCESS_MASTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define I2CRAM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CRAM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/i2cram_pkg.sv */
// Shared types and constants for the I2C register access master.
// No dependencies; used by the channel interfaces and the top level.
package i2cram_pkg;

  // Operation codes
  localparam logic [1:0] OP_WRITE     = 2'd0;
  localparam logic [1:0] OP_READ_BYTE = 2'd1;
  localparam logic [1:0] OP_READ_WORD = 2'd2;
  localparam logic [1:0] OP_READ_SIX  = 2'd3;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_HALF_STEP_TICKS = 1'b0;

  typedef struct packed {
    logic       start_request;
    logic [1:0] operation;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        sda_drive;
    logic        busy_res;
    logic        done_res;
    logic [15:0] first_word;
    logic [15:0] second_word;
  } res_t;

endpackage

/* hdl/i2cram_req_if.sv */
// Tick request channel: valid/ready handshake with a req_t payload.
// Depends on i2cram_pkg.
interface i2cram_req_if import i2cram_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/i2cram_res_if.sv */
// Tick result channel: valid/ready handshake with a res_t payload.
// Depends on i2cram_pkg.
interface i2cram_res_if import i2cram_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/i2c_register_access_master.sv */
// I2C register access master: runs one register transaction per start request
// on a bit-banged bus. Depends on i2cram_pkg, i2cram_req_if, i2cram_res_if
// and i2c_register_access_master_assert.svh.
//
// Each request transaction is one time tick of the pin sequencer and yields
// exactly one result transaction holding the pin levels of the phase in force
// during that tick, busy/done flags and the words read so far. Ticks are taken
// at one per clock cycle when not stalled: the whole sequencer update (phase,
// counters, shift register, read words) is one short combinational pass from
// the state registers into the state and result registers, so a result appears
// in the cycle after its tick is accepted. The result register decouples the
// two sides; a new tick is accepted whenever the result register is empty or
// is being taken in the same cycle. Operation 0 writes one register, 1 reads a
// byte, 2 reads a big-endian word, 3 reads six bytes (word from bytes 0-1
// and 4-5). Slave ACKs are clocked but not checked. Each pin segment lasts
// one or two delay units of half_step_ticks ticks (0 behaves as 1); the
// register lives at APB byte address 0 and should only be written while idle.
module i2c_register_access_master import i2cram_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  i2cram_req_if.sink            req,
  i2cram_res_if.source          res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  `include "i2c_register_access_master_assert.svh"

  // Sequencer phases, in bus order; unlisted phases simply step to the next
  typedef enum logic [4:0] {
    PH_IDLE, PH_RS0, PH_RS1, PH_ST0, PH_ST1, PH_ST2, PH_ST3, PH_ST4, PH_ST5,
    PH_TXL, PH_TXH, PH_TA0, PH_TA1, PH_TA2, PH_RXL, PH_RXH,
    PH_MA0, PH_MA1, PH_MA2, PH_MA3,
    PH_SP0, PH_SP1, PH_SP2, PH_SP3, PH_SP4, PH_SP5
  } phase_t;

  // Configuration
  logic [15:0] half_step_ticks;

  // Sequencer state
  phase_t      phase, phase_next;
  logic [3:0]  bit_counter, bit_counter_next;
  logic [2:0]  byte_counter, byte_counter_next;
  logic [7:0]  shift_register, shift_register_next;
  logic [15:0] delay_counter, delay_counter_next;
  logic [1:0]  held_operation, held_operation_next;
  logic [6:0]  held_device, held_device_next;
  logic [7:0]  held_register, held_register_next;
  logic [7:0]  held_data, held_data_next;
  logic [15:0] word_one, word_one_next;
  logic [15:0] word_two, word_two_next;

  // Result register
  logic res_valid;
  res_t res_data;

  // Combinational helpers
  logic        accept;
  logic        scl, sdl, drv, busy, done;
  logic        ack_bit;
  logic [2:0]  rx_count;
  logic [15:0] limit;
  logic [15:0] delay_sum;
  logic [3:0]  bit_inc;
  logic [2:0]  byte_inc;
  logic [7:0]  rx_byte;
  logic [7:0]  addr_wr, addr_rd;

  assign accept    = req.valid && req.ready;
  assign req.ready = !res_valid || res.ready;
  assign res.valid = res_valid;
  assign res.data  = res_data;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[CFG_ADDR_W-1] == REG_HALF_STEP_TICKS) begin
      prdata = {16'd0, half_step_ticks};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_step_ticks <= 16'd1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[CFG_ADDR_W-1] == REG_HALF_STEP_TICKS) begin
      half_step_ticks <= pwdata[15:0];
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign limit    = (half_step_ticks == 16'd0) ? 16'd1 : half_step_ticks;
  assign rx_count = (held_operation == OP_READ_BYTE) ? 3'd1 :
                    (held_operation == OP_READ_WORD) ? 3'd2 : 3'd6;
  // NACK the last byte, ACK the others
  assign ack_bit  = ({1'b0, byte_counter} + 4'd1) >= {1'b0, rx_count};
  assign delay_sum = delay_counter + 16'd1;
  assign bit_inc   = bit_counter + 4'd1;
  assign byte_inc  = byte_counter + 3'd1;
  assign rx_byte   = {shift_register[6:0], req.data.sda_in};
  assign addr_wr   = {held_device, 1'b0};
  assign addr_rd   = {held_device, 1'b1};

  always_comb begin
    phase_next          = phase;
    bit_counter_next    = bit_counter;
    byte_counter_next   = byte_counter;
    shift_register_next = shift_register;
    delay_counter_next  = delay_counter;
    held_operation_next = held_operation;
    held_device_next    = held_device;
    held_register_next  = held_register;
    held_data_next      = held_data;
    word_one_next       = word_one;
    word_two_next       = word_two;
    scl  = 1'b1;
    sdl  = 1'b1;
    drv  = 1'b1;
    busy = 1'b0;
    done = 1'b0;

    // Pins of the phase in force during this tick
    case (phase)
      PH_IDLE: ;
      PH_RS0, PH_RS1: begin scl = 1'b0; sdl = 1'b1; end
      PH_ST0, PH_ST1: begin scl = 1'b1; sdl = 1'b1; end
      PH_ST2, PH_ST3: begin scl = 1'b1; sdl = 1'b0; end
      PH_ST4, PH_ST5: begin scl = 1'b0; sdl = 1'b0; end
      PH_TXL: begin scl = 1'b0; sdl = shift_register[7]; end
      PH_TXH: begin scl = 1'b1; sdl = shift_register[7]; end
      PH_TA0, PH_TA1, PH_RXL: begin scl = 1'b0; drv = 1'b0; end
      PH_TA2, PH_RXH: begin scl = 1'b1; drv = 1'b0; end
      PH_MA0: begin scl = 1'b0; sdl = 1'b1; end
      PH_MA1, PH_MA3: begin scl = 1'b0; sdl = ack_bit; end
      PH_MA2: begin scl = 1'b1; sdl = ack_bit; end
      PH_SP0, PH_SP1: begin scl = 1'b0; sdl = 1'b0; end
      PH_SP2, PH_SP3: begin scl = 1'b1; sdl = 1'b0; end
      default: begin scl = 1'b1; sdl = 1'b1; end
    endcase

    if (phase == PH_IDLE) begin
      if (req.data.start_request) begin
        held_operation_next = req.data.operation;
        held_device_next    = req.data.device_address;
        held_register_next  = req.data.register_address;
        held_data_next      = req.data.write_data;
        if (req.data.operation != OP_WRITE) begin
          word_one_next = '0;
          word_two_next = '0;
        end
        byte_counter_next   = '0;
        bit_counter_next    = '0;
        shift_register_next = '0;
        delay_counter_next  = '0;
        phase_next          = PH_ST0;
      end
    end else begin
      busy = 1'b1;
      delay_counter_next = delay_sum;
      if (delay_sum >= limit) begin
        delay_counter_next = '0;
        done = (phase == PH_SP5);
        case (phase)
          PH_ST5: begin
            // Byte 0 is the write address; after a repeated start, the read address
            bit_counter_next = '0;
            phase_next       = PH_TXL;
            if (byte_counter == 3'd0) begin
              shift_register_next = addr_wr;
            end else if (byte_counter == 3'd1) begin
              shift_register_next = held_register;
            end else if (held_operation == OP_WRITE) begin
              shift_register_next = held_data;
            end else begin
              shift_register_next = addr_rd;
            end
          end
          PH_TXH: begin
            bit_counter_next = bit_inc;
            if (bit_inc < 4'd8) begin
              shift_register_next = {shift_register[6:0], 1'b0};
              phase_next          = PH_TXL;
            end else begin
              phase_next = PH_TA0;
            end
          end
          PH_TA2: begin
            if (byte_counter == 3'd0) begin
              byte_counter_next   = 3'd1;
              shift_register_next = held_register;
              bit_counter_next    = '0;
              phase_next          = PH_TXL;
            end else if (byte_counter == 3'd1) begin
              byte_counter_next = 3'd2;
              if (held_operation == OP_WRITE) begin
                shift_register_next = held_data;
                bit_counter_next    = '0;
                phase_next          = PH_TXL;
              end else begin
                phase_next = PH_RS0;
              end
            end else if (byte_counter == 3'd2 && held_operation != OP_WRITE) begin
              byte_counter_next   = '0;
              bit_counter_next    = '0;
              shift_register_next = '0;
              phase_next          = PH_RXL;
            end else begin
              phase_next = PH_SP0;
            end
          end
          PH_RXH: begin
            shift_register_next = rx_byte;
            bit_counter_next    = bit_inc;
            if (bit_inc < 4'd8) begin
              phase_next = PH_RXL;
            end else begin
              phase_next = PH_MA0;
              // Bytes two and three of a six-byte read are dropped
              if (held_operation == OP_READ_BYTE) begin
                word_one_next = {8'd0, rx_byte};
              end else if (byte_counter == 3'd0) begin
                word_one_next = {rx_byte, word_one[7:0]};
              end else if (byte_counter == 3'd1) begin
                word_one_next = {word_one[15:8], rx_byte};
              end else if (byte_counter == 3'd4) begin
                word_two_next = {rx_byte, word_two[7:0]};
              end else if (byte_counter == 3'd5) begin
                word_two_next = {word_two[15:8], rx_byte};
              end
            end
          end
          PH_MA3: begin
            byte_counter_next = byte_inc;
            if (byte_inc < rx_count) begin
              bit_counter_next    = '0;
              shift_register_next = '0;
              phase_next          = PH_RXL;
            end else begin
              phase_next = PH_SP0;
            end
          end
          PH_SP5: phase_next = PH_IDLE;
          default: phase_next = phase_t'(phase + 5'd1);
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_counter    <= '0;
      byte_counter   <= '0;
      shift_register <= '0;
      delay_counter  <= '0;
      held_operation <= '0;
      held_device    <= '0;
      held_register  <= '0;
      held_data      <= '0;
      word_one       <= '0;
      word_two       <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      bit_counter    <= bit_counter_next;
      byte_counter   <= byte_counter_next;
      shift_register <= shift_register_next;
      delay_counter  <= delay_counter_next;
      held_operation <= held_operation_next;
      held_device    <= held_device_next;
      held_register  <= held_register_next;
      held_data      <= held_data_next;
      word_one       <= word_one_next;
      word_two       <= word_two_next;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_data.scl_level   <= scl;
      res_data.sda_level   <= sdl;
      res_data.sda_drive   <= drv;
      res_data.busy_res    <= busy;
      res_data.done_res    <= done;
      res_data.first_word  <= word_one_next;
      res_data.second_word <= word_two_next;
    end
  end

  // ---------------------------------------------------------------- assertions
  `I2CRAM_ASSERT_NXT(a_start_enters_st0, accept && phase == PH_IDLE && req.data.start_request, phase == PH_ST0, "start request did not enter start phase")
  `I2CRAM_ASSERT_IMP(a_bit_count_range, phase != PH_IDLE, bit_counter <= 4'd8, "bit counter ran past eight")
  `I2CRAM_ASSERT_IMP(a_done_while_busy, res.valid && res.data.done_res, res.data.busy_res, "done flagged outside a transaction")
  `I2CRAM_ASSERT_IMP(a_stall_only_when_full, !req.ready, res.valid, "request stalled with empty result register")

endmodule

/* dv/tb_top.sv */
// Testbench for the I2C register access master: directed plan, then random ticks.
// Checks every result against a tick-level model of the pin sequencer or a typed-in result.
// Depends on i2cram_pkg, i2cram_req_if, i2cram_res_if and the top level.
module tb_top import i2cram_pkg::*; ();

  // Run limits and knobs
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned SETTLE_CYCLES = 4;       // result register is one deep
  localparam int unsigned HOLD_CYCLES = 400;       // long receiver hold-off
  localparam int unsigned RANDOM_TICKS_PER_SET = 12;
  localparam logic [15:0] FOLLOW_TO_IDLE = 16'hFFFF;

  // Configuration register indexes
  localparam int unsigned IDX_HALF_STEP = int'(REG_HALF_STEP_TICKS);
  localparam int unsigned IDX_SPARE = 1;           // unmapped, writes are dropped

  // Delay unit settings for the random sets: mostly fast, zero acts as one
  localparam logic [15:0] RANDOM_DELAYS [6] = '{16'd1, 16'd2, 16'd0, 16'd1, 16'd3, 16'd1};

  // Sequencer phases, in the order the default path steps through them
  typedef enum logic [5:0] {
    S_IDLE, S_RS0, S_RS1,
    S_ST0, S_ST1, S_ST2, S_ST3, S_ST4, S_ST5,
    S_TXL, S_TXH, S_TA0, S_TA1, S_TA2,
    S_RXL, S_RXH, S_MA0, S_MA1, S_MA2, S_MA3,
    S_SP0, S_SP1, S_SP2, S_SP3, S_SP4, S_SP5
  } phase_t;

  typedef struct packed {
    phase_t      ph;
    logic [3:0]  bit_cnt;
    logic [2:0]  byte_cnt;
    logic [7:0]  shreg;
    logic [15:0] dly;
    logic [1:0]  op;
    logic [6:0]  dev;
    logic [7:0]  regad;
    logic [7:0]  wdat;
    logic [15:0] w1;
    logic [15:0] w2;
  } seq_state_t;

  typedef enum logic { ROW_TICK, ROW_CFG } row_kind_t;
  typedef enum logic [1:0] { SDA_LOW, SDA_HIGH, SDA_RANDOM } sda_fill_t;

  // One line of the directed plan: either a tick (plus follow-on ticks) or a
  // register write made once the block has gone quiet.
  typedef struct packed {
    row_kind_t   kind;
    req_t        tick;
    sda_fill_t   fill;
    logic [15:0] follow;
    logic        poke;        // start_request held high in follow-on ticks
    logic        known;       // expected result typed in rather than predicted
    res_t        known_res;
    logic [2:0]  cfg_idx;
    logic [15:0] cfg_val;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  i2cram_req_if req_ch ();
  i2cram_res_if res_ch ();

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  i2c_register_access_master uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // 8 time unit clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model state, its copy of the delay register, and the results it owes
  seq_state_t  bm;
  logic [15:0] bm_half_step;
  res_t        expected_pins_q [$];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          send_burst = 1'b0;
  bit          take_burst = 1'b0;
  bit          hold_trigger = 1'b0;
  logic        long_hold = 1'b0;
  plan_row_t   plan [$];

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  function automatic logic [2:0] bytes_to_read(input logic [1:0] op);
    if (op == OP_READ_BYTE) return 3'd1;
    if (op == OP_READ_WORD) return 3'd2;
    return 3'd6;
  endfunction

  // Load the next outgoing byte: address+W, register, then data or address+R
  function automatic void load_byte(input logic [2:0] idx);
    if (idx == 3'd0) bm.shreg = {bm.dev, 1'b0};
    else if (idx == 3'd1) bm.shreg = bm.regad;
    else if (bm.op == OP_WRITE) bm.shreg = bm.wdat;
    else bm.shreg = {bm.dev, 1'b1};
    bm.bit_cnt = '0;
    bm.ph = S_TXL;
  endfunction

  // One tick of the pin sequencer: pins come from the phase in force, then the
  // state moves on; the words reported are those after the update.
  function automatic void sequencer_tick(input req_t t, output res_t r);
    int unsigned limit;
    logic        bit_out;
    logic        ack;
    limit = (bm_half_step == 16'd0) ? 1 : int'(bm_half_step);
    bit_out = bm.shreg[7];
    ack = (int'(bm.byte_cnt) + 1 >= int'(bytes_to_read(bm.op)));

    r = '0;
    r.scl_level = 1'b1;
    r.sda_level = 1'b1;
    r.sda_drive = 1'b1;
    case (bm.ph)
      S_IDLE: ;
      S_RS0, S_RS1: r.scl_level = 1'b0;
      S_ST0, S_ST1: ;
      S_ST2, S_ST3: r.sda_level = 1'b0;
      S_ST4, S_ST5, S_SP0, S_SP1: begin
        r.scl_level = 1'b0;
        r.sda_level = 1'b0;
      end
      S_TXL: begin
        r.scl_level = 1'b0;
        r.sda_level = bit_out;
      end
      S_TXH: r.sda_level = bit_out;
      S_TA0, S_TA1, S_RXL: begin
        r.scl_level = 1'b0;
        r.sda_drive = 1'b0;
      end
      S_TA2, S_RXH: r.sda_drive = 1'b0;
      S_MA0: r.scl_level = 1'b0;
      S_MA1, S_MA3: begin
        r.scl_level = 1'b0;
        r.sda_level = ack;
      end
      S_MA2: r.sda_level = ack;
      S_SP2, S_SP3: r.sda_level = 1'b0;
      default: ;
    endcase

    if (bm.ph == S_IDLE) begin
      if (t.start_request) begin
        bm.op = t.operation;
        bm.dev = t.device_address;
        bm.regad = t.register_address;
        bm.wdat = t.write_data;
        if (bm.op != OP_WRITE) begin
          bm.w1 = '0;
          bm.w2 = '0;
        end
        bm.byte_cnt = '0;
        bm.bit_cnt = '0;
        bm.shreg = '0;
        bm.dly = '0;
        bm.ph = S_ST0;
      end
    end else begin
      r.busy_res = 1'b1;
      bm.dly = bm.dly + 16'd1;
      if (bm.dly >= limit) begin
        bm.dly = '0;
        if (bm.ph == S_SP5) r.done_res = 1'b1;
        case (bm.ph)
          S_ST5: load_byte(bm.byte_cnt);
          S_TXH: begin
            bm.bit_cnt = bm.bit_cnt + 4'd1;
            if (bm.bit_cnt < 4'd8) begin
              bm.shreg = bm.shreg << 1;
              bm.ph = S_TXL;
            end else begin
              bm.ph = S_TA0;
            end
          end
          S_TA2: begin
            if (bm.byte_cnt == 3'd0) begin
              bm.byte_cnt = 3'd1;
              load_byte(3'd1);
            end else if (bm.byte_cnt == 3'd1) begin
              bm.byte_cnt = 3'd2;
              if (bm.op == OP_WRITE) load_byte(3'd2);
              else bm.ph = S_RS0;
            end else if (bm.byte_cnt == 3'd2 && bm.op != OP_WRITE) begin
              bm.byte_cnt = '0;
              bm.bit_cnt = '0;
              bm.shreg = '0;
              bm.ph = S_RXL;
            end else begin
              bm.ph = S_SP0;
            end
          end
          S_RXH: begin
            bm.shreg = {bm.shreg[6:0], t.sda_in};
            bm.bit_cnt = bm.bit_cnt + 4'd1;
            if (bm.bit_cnt < 4'd8) begin
              bm.ph = S_RXL;
            end else begin
              // bytes 2 and 3 of a six-byte read fall through and are lost
              if (bm.op == OP_READ_BYTE) begin
                bm.w1 = {8'h00, bm.shreg};
              end else begin
                case (bm.byte_cnt)
                  3'd0: bm.w1[15:8] = bm.shreg;
                  3'd1: bm.w1[7:0] = bm.shreg;
                  3'd4: bm.w2[15:8] = bm.shreg;
                  3'd5: bm.w2[7:0] = bm.shreg;
                  default: ;
                endcase
              end
              bm.ph = S_MA0;
            end
          end
          S_MA3: begin
            bm.byte_cnt = bm.byte_cnt + 3'd1;
            if (bm.byte_cnt < bytes_to_read(bm.op)) begin
              bm.bit_cnt = '0;
              bm.shreg = '0;
              bm.ph = S_RXL;
            end else begin
              bm.ph = S_SP0;
            end
          end
          S_SP5: bm.ph = S_IDLE;
          default: bm.ph = phase_t'(bm.ph + 6'd1);
        endcase
      end
    end
    r.first_word = bm.w1;
    r.second_word = bm.w2;
  endfunction

  // Idle bus pins with the given read words
  function automatic res_t idle_result(input logic [15:0] w1, input logic [15:0] w2);
    return res_t'({1'b1, 1'b1, 1'b1, 1'b0, 1'b0, w1, w2});
  endfunction

  function automatic plan_row_t tick_row(input logic start, input logic [1:0] op,
                                         input logic [6:0] dev, input logic [7:0] regad,
                                         input logic [7:0] wdat, input sda_fill_t fill,
                                         input logic [15:0] follow, input logic poke,
                                         input logic known, input res_t known_res);
    plan_row_t row;
    row = '0;
    row.kind = ROW_TICK;
    row.tick.start_request = start;
    row.tick.operation = op;
    row.tick.device_address = dev;
    row.tick.register_address = regad;
    row.tick.write_data = wdat;
    row.fill = fill;
    row.follow = follow;
    row.poke = poke;
    row.known = known;
    row.known_res = known_res;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input int unsigned idx, input logic [15:0] val);
    plan_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.cfg_idx = idx[2:0];
    row.cfg_val = val;
    return row;
  endfunction

  function automatic logic sda_bit(input sda_fill_t fill);
    if (fill == SDA_LOW) return 1'b0;
    if (fill == SDA_HIGH) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic req_t random_tick(input logic start);
    req_t t;
    t.start_request = start;
    t.operation = 2'($urandom_range(0, 3));
    t.device_address = 7'($urandom_range(0, 127));
    t.register_address = 8'($urandom_range(0, 255));
    t.write_data = 8'($urandom_range(0, 255));
    t.sda_in = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // Offer one tick after a random gap; returns on the edge that takes it.
  // The model runs at acceptance so register writes stay in order.
  task automatic send_tick(input req_t t, input logic known, input res_t known_res);
    int   gap;
    res_t predicted;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= t;
    do @(posedge clk); while (!req_ch.ready);
    sequencer_tick(t, predicted);
    expected_pins_q.push_back(known ? known_res : predicted);
  endtask

  // Stop offering and wait for every owed result, plus the result register
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (expected_pins_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB transaction, setup phase then access phase; the access completes on the edge with pready
  task automatic apb_access(input bit wr, input int unsigned idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= CFG_ADDR_W'(idx << 2);
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Register write once quiet, then read the delay register back
  task automatic settle_and_config(input int unsigned idx, input logic [15:0] value);
    logic [31:0] rd;
    drain_results();
    apb_access(1'b1, idx, {16'h0000, value}, rd);
    if (idx == IDX_HALF_STEP) bm_half_step = value;
    apb_access(1'b0, IDX_HALF_STEP, '0, rd);
    if (rd[15:0] !== bm_half_step)
      flag_mismatch($sformatf("delay register read %h, expected %h", rd[15:0], bm_half_step));
  endtask

  // Long receiver hold-off so the block fills and back-pressures its input
  initial begin
    wait (hold_trigger);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Result side: random stalls, then compare against the oldest expectation
  initial begin
    int   gap;
    res_t want;
    res_t got;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
      gap = take_burst ? 0 : $urandom_range(0, 17);
      if (gap > 0 || long_hold) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (long_hold) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      got = res_ch.data;
      if (expected_pins_q.size() == 0) begin
        flag_mismatch($sformatf("result with nothing owed: %p", got));
      end else begin
        want = expected_pins_q.pop_front();
        if (got.scl_level !== want.scl_level || got.sda_level !== want.sda_level ||
            got.sda_drive !== want.sda_drive || got.busy_res !== want.busy_res ||
            got.done_res !== want.done_res || got.first_word !== want.first_word ||
            got.second_word !== want.second_word)
          flag_mismatch($sformatf("expected %p got %p", want, got));
      end
    end
  end

  // Stimulus
  initial begin
    plan_row_t   row;
    req_t        t;
    int unsigned n;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    bm = '0;
    bm_half_step = 16'd1;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed plan. Typed-in results only where obvious: idle pins on the
    // request tick, with words still zero, cleared by a read, or held by a write.
    plan = '{
      // idle bus straight after reset
      tick_row(1'b0, OP_WRITE, 7'h00, 8'h00, 8'h00, SDA_LOW, 16'd0, 1'b0,
               1'b1, idle_result(16'h0000, 16'h0000)),
      // write with every address and data bit set
      tick_row(1'b1, OP_WRITE, 7'h7F, 8'hFF, 8'hFF, SDA_HIGH, FOLLOW_TO_IDLE, 1'b0,
               1'b1, idle_result(16'h0000, 16'h0000)),
      // six-byte read of all ones, pestered with requests while busy
      tick_row(1'b1, OP_READ_SIX, 7'h00, 8'h00, 8'h00, SDA_HIGH, FOLLOW_TO_IDLE, 1'b1,
               1'b1, idle_result(16'h0000, 16'h0000)),
      // a write leaves the words from the read alone
      tick_row(1'b1, OP_WRITE, 7'h55, 8'hAA, 8'h5A, SDA_RANDOM, FOLLOW_TO_IDLE, 1'b1,
               1'b1, idle_result(16'hFFFF, 16'hFFFF)),
      // a read clears them as it starts
      tick_row(1'b1, OP_READ_BYTE, 7'h2A, 8'h55, 8'hA5, SDA_LOW, FOLLOW_TO_IDLE, 1'b0,
               1'b1, idle_result(16'h0000, 16'h0000)),
      // zero delay behaves as one
      cfg_row(IDX_HALF_STEP, 16'd0),
      tick_row(1'b1, OP_READ_WORD, 7'h7F, 8'h00, 8'hFF, SDA_RANDOM, FOLLOW_TO_IDLE, 1'b0,
               1'b0, '0),
      cfg_row(IDX_HALF_STEP, 16'd2),
      tick_row(1'b1, OP_READ_SIX, 7'h13, 8'h3C, 8'h00, SDA_RANDOM, FOLLOW_TO_IDLE, 1'b1,
               1'b0, '0),
      // slowest setting, then cut short part-way through a segment
      cfg_row(IDX_HALF_STEP, 16'hFFFF),
      tick_row(1'b1, OP_READ_BYTE, 7'h01, 8'h80, 8'h00, SDA_RANDOM, 16'd40, 1'b0,
               1'b0, '0),
      cfg_row(IDX_HALF_STEP, 16'd1),
      tick_row(1'b0, OP_WRITE, 7'h00, 8'h00, 8'h00, SDA_RANDOM, FOLLOW_TO_IDLE, 1'b0,
               1'b0, '0),
      // unmapped register index must not disturb anything
      cfg_row(IDX_SPARE, 16'd3),
      tick_row(1'b1, OP_READ_WORD, 7'h00, 8'hFF, 8'h00, SDA_HIGH, FOLLOW_TO_IDLE, 1'b0,
               1'b0, '0),
      tick_row(1'b1, OP_WRITE, 7'h00, 8'h00, 8'h00, SDA_LOW, FOLLOW_TO_IDLE, 1'b0,
               1'b0, '0)
    };

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_CFG) begin
        settle_and_config(int'(row.cfg_idx), row.cfg_val);
      end else begin
        t = row.tick;
        t.sda_in = sda_bit(row.fill);
        send_tick(t, row.known, row.known_res);
        n = 0;
        while ((row.follow == FOLLOW_TO_IDLE) ? (bm.ph != S_IDLE) : (n < row.follow)) begin
          t = random_tick(row.poke);
          t.sda_in = sda_bit(row.fill);
          send_tick(t, 1'b0, '0);
          n++;
        end
      end
    end

    // Random ticks: start requested most of the time so transactions run
    // back to back; anything offered while busy is just a bus tick.
    foreach (RANDOM_DELAYS[s]) begin
      settle_and_config(IDX_HALF_STEP, RANDOM_DELAYS[s]);
      for (int k = 0; k < RANDOM_TICKS_PER_SET; k++) begin
        if (s == 1 && k == 6) hold_trigger = 1'b1;
        send_tick(random_tick($urandom_range(0, 9) < 8), 1'b0, '0);
      end
    end

    drain_results();
    if (mismatches == 0 && expected_pins_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
